/* hdl/tempo_beat_clock_defines.svh */
// Assertion macros shared by the tempo beat clock RTL.
`ifndef TEMPO_BEAT_CLOCK_DEFINES_SVH
`define TEMPO_BEAT_CLOCK_DEFINES_SVH
`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside reset.
`define TBC_ASSERT(label, clk_s, rstn_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
        else $error(msg);
// Checks that a condition is never true at a clock edge outside reset.
`define TBC_ASSERT_NEVER(label, clk_s, rstn_s, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
        else $error(msg);
`else
`define TBC_ASSERT(label, clk_s, rstn_s, prop, msg)
`define TBC_ASSERT_NEVER(label, clk_s, rstn_s, cond, msg)
`endif
`endif

/* hdl/tbc_pkg.sv */
// Types and constants shared by the tempo beat clock modules.
package tbc_pkg;

    localparam int TEMPO_W    = 17;
    localparam int RATE_W     = 18;
    localparam int Q16_W      = 17;
    localparam int PERIOD_W   = 40;
    localparam int SCALE_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int BEAT_NUM_W = 32;

    localparam logic [Q16_W-1:0]    UNITY          = 17'd65536;
    localparam logic [TEMPO_W-1:0]  TEMPO_RESET    = 17'd12000;
    localparam logic [TEMPO_W-1:0]  GLIDE_DEADBAND = 17'd10;
    localparam logic [12:0]         TEMPO_SCALE    = 13'd6000;
    localparam logic [15:0]         ROUND_HALF     = 16'd32768;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX     = 40'hFF_FFFF_FFFF;

    localparam logic [TEMPO_W-1:0] MIN_TEMPO_RESET    = 17'd2000;
    localparam logic [TEMPO_W-1:0] MAX_TEMPO_RESET    = 17'd30000;
    localparam logic [Q16_W-1:0]   GLIDE_FACTOR_RESET = 17'd6554;
    localparam logic [Q16_W-1:0]   FADE_FACTOR_RESET  = 17'd62259;
    localparam logic [Q16_W-1:0]   PULSE_FLOOR_RESET  = 17'd655;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_FLOOR  = 3'd4;

    typedef enum logic [2:0] {
        OP_FRAME      = 3'd0,
        OP_BUF_BEGIN  = 3'd1,
        OP_BUF_END    = 3'd2,
        OP_SET_TEMPO  = 3'd3,
        OP_START      = 3'd4,
        OP_STOP       = 3'd5,
        OP_PAUSE      = 3'd6,
        OP_RESET      = 3'd7
    } op_t;

    typedef struct packed {
        logic [TEMPO_W-1:0] min_tempo;
        logic [TEMPO_W-1:0] max_tempo;
        logic [Q16_W-1:0]   glide_factor;
        logic [Q16_W-1:0]   fade_factor;
        logic [Q16_W-1:0]   pulse_floor;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [RATE_W-1:0]  rate;
        logic [TEMPO_W-1:0] tempo;
    } cmd_t;

    typedef struct packed {
        logic                  fired;
        logic [BEAT_NUM_W-1:0] beat_number;
        logic [TEMPO_W-1:0]    tempo;
        logic [Q16_W-1:0]      pulse;
        logic                  running;
    } res_t;

endpackage

/* hdl/tempo_beat_clock.sv */
// Top level of the tempo beat clock: command queue, front end, back end and result queue.

// Usage: the block keeps an audio-rate tempo clock. Each input word carries an
// operation (frame tick, buffer begin with a sample rate, buffer end, set tempo,
// start, stop, pause or reset) and yields exactly one result word with the beat
// flag, the running beat count, the smoothed tempo, the pulse level and the run
// flag. Input words enter a two-word command queue (push/full); result words
// leave through a two-word result queue (empty/pop), so a result waiting to be
// taken does not hold up the input side. The back end executes one command at a
// time. A frame tick, set tempo, start, stop, pause, reset, and any command that
// the run state makes a no-op, finish when taken, so frames stream at one per
// cycle while the result queue has room. A buffer end while running goes through
// S_FADE_A (multiply) and S_FADE_B (floor test); a buffer begin while running
// through S_GLIDE_A, S_GLIDE_B and S_GLIDE_C when the tempo glides (the two glide
// products and their sum), then S_SCALE and S_DIV, where the bit-serial divider
// forms samples per beat one quotient bit per cycle. With a current tempo of
// zero the division is skipped and the period saturates. Configuration
// registers are written through cfg_valid/cfg_index/cfg_data, always ready,
// and must be written only while the block is idle; indexes beyond the five
// registers are ignored. Tempo is in 0.01 bpm units, fractions are Q1.16.
module tempo_beat_clock #(
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [2:0]                       operation,
    input  logic [tbc_pkg::RATE_W-1:0]       rate_hz,
    input  logic [tbc_pkg::TEMPO_W-1:0]      requested_tempo,
    output logic                             empty,
    input  logic                             pop,
    output logic                             beat_fired,
    output logic [tbc_pkg::BEAT_NUM_W-1:0]   beat_number,
    output logic [tbc_pkg::TEMPO_W-1:0]      tempo_now,
    output logic [tbc_pkg::Q16_W-1:0]        pulse_level,
    output logic                             running,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbc_pkg::Q16_W-1:0]        cfg_data
);
    import tbc_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    cfg_t                 cfg_reg;
    cmd_t                 front_cmd;
    cmd_t                 back_cmd;
    logic [$bits(cmd_t)-1:0] cmd_wr_word;
    logic [$bits(cmd_t)-1:0] cmd_rd_word;
    logic                 cmd_push;
    logic                 cmd_full;
    logic                 cmd_empty;
    logic                 cmd_pop;
    res_t                 back_res;
    res_t                 out_res;
    logic [$bits(res_t)-1:0] res_wr_word;
    logic [$bits(res_t)-1:0] res_rd_word;
    logic                 res_push;
    logic                 res_full;

    // The register file accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_tempo    <= MIN_TEMPO_RESET;
            cfg_reg.max_tempo    <= MAX_TEMPO_RESET;
            cfg_reg.glide_factor <= GLIDE_FACTOR_RESET;
            cfg_reg.fade_factor  <= FADE_FACTOR_RESET;
            cfg_reg.pulse_floor  <= PULSE_FLOOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MIN_TEMPO:    cfg_reg.min_tempo    <= cfg_data;
                CFG_MAX_TEMPO:    cfg_reg.max_tempo    <= cfg_data;
                CFG_GLIDE_FACTOR: cfg_reg.glide_factor <= cfg_data;
                CFG_FADE_FACTOR:  cfg_reg.fade_factor  <= cfg_data;
                CFG_PULSE_FLOOR:  cfg_reg.pulse_floor  <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The front end decodes each word and clamps tempo requests on the way in.
    tbc_front u_front (
        .push            (push),
        .operation       (operation),
        .rate_hz         (rate_hz),
        .requested_tempo (requested_tempo),
        .cfg             (cfg_reg),
        .q_full          (cmd_full),
        .cmd_push        (cmd_push),
        .cmd             (front_cmd)
    );

    assign full        = cmd_full;
    assign cmd_wr_word = front_cmd;

    tbc_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wr_word),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd_word),
        .empty   (cmd_empty)
    );

    assign back_cmd = cmd_rd_word;

    // The back end owns the clock state, the glide and fade multiplies and the
    // divider; it takes a command only when the result queue has room.
    tbc_back #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    assign res_wr_word = back_res;

    tbc_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_wr_word),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_word),
        .empty   (empty)
    );

    assign out_res     = res_rd_word;
    assign beat_fired  = out_res.fired;
    assign beat_number = out_res.beat_number;
    assign tempo_now   = out_res.tempo;
    assign pulse_level = out_res.pulse;
    assign running     = out_res.running;

endmodule

/* hdl/tbc_queue.sv */
// Small register queue used between the front, the back and the result port.
`include "tempo_beat_clock_defines.svh"

module tbc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `TBC_ASSERT_NEVER(a_full_and_empty, clk, rst_n, full && empty, "queue full and empty")
    `TBC_ASSERT(a_count_up, clk, rst_n, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not rise on a push")
    `TBC_ASSERT(a_count_down, clk, rst_n, (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1), "queue count did not fall on a pop")

endmodule

/* hdl/tbc_front.sv */
// Front end: accepts input words, decodes the operation and clamps tempo requests.
module tbc_front (
    input  logic                          push,
    input  logic [2:0]                    operation,
    input  logic [tbc_pkg::RATE_W-1:0]    rate_hz,
    input  logic [tbc_pkg::TEMPO_W-1:0]   requested_tempo,
    input  tbc_pkg::cfg_t                 cfg,
    input  logic                          q_full,
    output logic                          cmd_push,
    output tbc_pkg::cmd_t                 cmd
);
    import tbc_pkg::*;

    logic [TEMPO_W-1:0] clamped;

    // Lower limit first; inverted limits give min_tempo below it, else max_tempo.
    always_comb
    begin
        if (requested_tempo < cfg.min_tempo)
        begin
            clamped = cfg.min_tempo;
        end
        else if (requested_tempo > cfg.max_tempo)
        begin
            clamped = cfg.max_tempo;
        end
        else
        begin
            clamped = requested_tempo;
        end
    end

    assign cmd_push  = push && !q_full;
    assign cmd.op    = op_t'(operation);
    assign cmd.rate  = rate_hz;
    assign cmd.tempo = clamped;

endmodule

/* hdl/tbc_divider.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module tbc_divider #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 17
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});
    assign done      = done_reg;
    assign quot      = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= num;
            den_reg  <= den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            rem_reg  <= fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

endmodule

/* hdl/tbc_back.sv */
// Back end: holds the clock state and carries out one decoded command at a time.
`include "tempo_beat_clock_defines.svh"

module tbc_back #(
    parameter int FRAC_BITS   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tbc_pkg::cfg_t cfg,
    input  tbc_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  logic          res_full,
    output logic          res_push,
    output tbc_pkg::res_t res
);
    import tbc_pkg::*;

    localparam int NUM_W  = SCALE_W + FRAC_BITS;
    localparam int QX_W   = (NUM_W > PERIOD_W) ? NUM_W : PERIOD_W;
    localparam int GSUM_W = 35;
    localparam int PROD_W = 34;
    localparam logic [PERIOD_W-1:0] PHASE_STEP = PERIOD_W'(1) << FRAC_BITS;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_GLIDE_A = 8'b0000_0010,
        S_GLIDE_B = 8'b0000_0100,
        S_GLIDE_C = 8'b0000_1000,
        S_SCALE   = 8'b0001_0000,
        S_DIV     = 8'b0010_0000,
        S_FADE_A  = 8'b0100_0000,
        S_FADE_B  = 8'b1000_0000
    } state_t;

    function automatic logic [Q16_W-1:0] sat_unity(input logic [Q16_W-1:0] v);
        return (v > UNITY) ? UNITY : v;
    endfunction

    state_t                 state_reg, state_next;
    logic                   run_reg, run_next;
    logic [TEMPO_W-1:0]     cur_reg, cur_next;
    logic [TEMPO_W-1:0]     tgt_reg, tgt_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    logic [PERIOD_W-1:0]    phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [Q16_W-1:0]       pulse_reg, pulse_next;
    logic [PROD_W-1:0]      prod_a_reg;
    logic [PROD_W-1:0]      prod_b_reg;
    logic                   fired;

    logic [Q16_W-1:0]    g_sat;
    logic [Q16_W-1:0]    g_comp;
    logic [Q16_W-1:0]    f_sat;
    logic [TEMPO_W-1:0]  tempo_gap;
    logic [RATE_W-1:0]   rate_gap;
    logic [PERIOD_W-1:0] phase_step;
    logic [PERIOD_W:0]   phase_sub;
    logic [GSUM_W-1:0]   glide_sum;
    logic [Q16_W-1:0]    faded;
    logic [SCALE_W-1:0]  scale_prod;
    logic [NUM_W-1:0]    div_num;
    logic [NUM_W-1:0]    div_quot;
    logic [QX_W-1:0]     quot_ext;
    logic                div_start;
    logic                div_done;

    assign g_sat      = sat_unity(cfg.glide_factor);
    assign g_comp     = UNITY - g_sat;
    assign f_sat      = sat_unity(cfg.fade_factor);
    assign tempo_gap  = (cur_reg > tgt_reg) ? cur_reg - tgt_reg : tgt_reg - cur_reg;
    assign rate_gap   = (cmd.rate > rate_reg) ? cmd.rate - rate_reg : rate_reg - cmd.rate;
    assign phase_step = phase_reg + PHASE_STEP;
    assign phase_sub  = {1'b0, phase_step} - {1'b0, period_reg};
    assign glide_sum  = GSUM_W'(prod_a_reg) + GSUM_W'(prod_b_reg) + GSUM_W'(ROUND_HALF);
    assign faded      = prod_a_reg[32:16];
    assign scale_prod = SCALE_W'(rate_reg) * SCALE_W'(TEMPO_SCALE);
    assign div_num    = NUM_W'(scale_prod) << FRAC_BITS;
    assign quot_ext   = QX_W'(div_quot);

    tbc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (TEMPO_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (cur_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next  = state_reg;
        run_next    = run_reg;
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        rate_next   = rate_reg;
        period_next = period_reg;
        phase_next  = phase_reg;
        count_next  = count_reg;
        pulse_next  = pulse_reg;
        fired       = 1'b0;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        div_start   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop  = 1'b1;
                    res_push = 1'b1;
                    case (cmd.op)
                        OP_FRAME:
                        begin
                            if (run_reg && (period_reg != '0))
                            begin
                                if (!phase_sub[PERIOD_W])
                                begin
                                    phase_next = phase_sub[PERIOD_W-1:0];
                                    count_next = count_reg + COUNT_WIDTH'(1);
                                    pulse_next = UNITY;
                                    fired      = 1'b1;
                                end
                                else
                                begin
                                    phase_next = phase_step;
                                end
                            end
                        end
                        OP_BUF_BEGIN:
                        begin
                            if (run_reg)
                            begin
                                res_push = 1'b0;
                                if ((cmd.rate != '0) &&
                                    ((rate_reg == '0) || (rate_gap > RATE_W'(1))))
                                begin
                                    rate_next = cmd.rate;
                                end
                                state_next = (tempo_gap > GLIDE_DEADBAND) ? S_GLIDE_A : S_SCALE;
                            end
                        end
                        OP_BUF_END:
                        begin
                            if (run_reg)
                            begin
                                res_push   = 1'b0;
                                state_next = S_FADE_A;
                            end
                        end
                        OP_SET_TEMPO:
                        begin
                            if ((cmd.tempo != '0) && (cmd.tempo != tgt_reg))
                            begin
                                tgt_next = cmd.tempo;
                            end
                        end
                        OP_START:
                        begin
                            if (!run_reg)
                            begin
                                run_next   = 1'b1;
                                phase_next = '0;
                            end
                        end
                        OP_STOP:
                        begin
                            if (run_reg)
                            begin
                                run_next   = 1'b0;
                                pulse_next = '0;
                                phase_next = '0;
                            end
                        end
                        OP_PAUSE:
                        begin
                            run_next = 1'b0;
                        end
                        OP_RESET:
                        begin
                            run_next   = 1'b0;
                            pulse_next = '0;
                            phase_next = '0;
                        end
                        default:
                        begin
                            run_next = run_reg;
                        end
                    endcase
                end
            end
            S_GLIDE_A:
            begin
                state_next = S_GLIDE_B;
            end
            S_GLIDE_B:
            begin
                state_next = S_GLIDE_C;
            end
            S_GLIDE_C:
            begin
                cur_next   = glide_sum[32:16];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (cur_reg == '0)
                begin
                    period_next = PERIOD_MAX;
                    res_push    = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    period_next = (quot_ext > QX_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                                  : PERIOD_W'(quot_ext);
                    res_push    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FADE_A:
            begin
                state_next = S_FADE_B;
            end
            S_FADE_B:
            begin
                pulse_next = (faded < cfg.pulse_floor) ? '0 : faded;
                res_push   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.fired       = fired;
    assign res.beat_number = BEAT_NUM_W'(count_next);
    assign res.tempo       = cur_next;
    assign res.pulse       = pulse_next;
    assign res.running     = run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            run_reg    <= 1'b0;
            cur_reg    <= TEMPO_RESET;
            tgt_reg    <= TEMPO_RESET;
            rate_reg   <= '0;
            period_reg <= '0;
            phase_reg  <= '0;
            count_reg  <= '0;
            pulse_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            run_reg    <= run_next;
            cur_reg    <= cur_next;
            tgt_reg    <= tgt_next;
            rate_reg   <= rate_next;
            period_reg <= period_next;
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            pulse_reg  <= pulse_next;
        end
    end

    // Products for the tempo glide and the pulse fade, one multiply per cycle.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_GLIDE_A: prod_a_reg <= cur_reg * g_comp;
            S_GLIDE_B: prod_b_reg <= tgt_reg * g_sat;
            S_FADE_A:  prod_a_reg <= pulse_reg * f_sat;
            default:   prod_b_reg <= prod_b_reg;
        endcase
    end

    `TBC_ASSERT_NEVER(a_push_into_full, clk, rst_n, res_push && res_full, "result pushed into a full queue")
    `TBC_ASSERT(a_div_done_in_div, clk, rst_n, div_done |-> (state_reg == S_DIV), "divider finished outside the divide step")
    `TBC_ASSERT(a_long_ops_running, clk, rst_n, (state_reg != S_IDLE) |-> run_reg, "multi-cycle command while stopped")

endmodule

/* tb/tb_tempo_beat_clock.sv */
// Self-checking testbench for the tempo beat clock: directed table, random traffic, idle and stall phases.
module tb_tempo_beat_clock;
    import tbc_pkg::*;

    // The block is built with its default fraction width, and the beat count is as wide as the
    // beat_number port.
    localparam int FRAC_BITS = 8;
    localparam logic [PERIOD_W-1:0] PHASE_STEP = PERIOD_W'(1) << FRAC_BITS;

    // The longest command is a buffer begin that glides. After the last expected word has come
    // we wait longer than such a command takes before touching the registers or ending the run.
    localparam int SETTLE_CYCLES  = 60;
    // The receiver's long hold-off, long enough to fill both queues and stall the input side.
    localparam int HOLD_CYCLES    = 300;
    // Cycles without any word moving before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Live words per random segment.
    localparam int SEGMENT_WORDS  = 200;
    // Highest index the configuration port can carry; those above the pulse floor are unused.
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = 3'd7;

    logic                  clk             = 1'b0;
    logic                  rst_n           = 1'b0;
    logic                  push            = 1'b0;
    logic                  full;
    logic [2:0]            operation       = OP_FRAME;
    logic [RATE_W-1:0]     rate_hz         = '0;
    logic [TEMPO_W-1:0]    requested_tempo = '0;
    logic                  empty;
    logic                  pop             = 1'b0;
    logic                  beat_fired;
    logic [BEAT_NUM_W-1:0] beat_number;
    logic [TEMPO_W-1:0]    tempo_now;
    logic [Q16_W-1:0]      pulse_level;
    logic                  running;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [Q16_W-1:0]      cfg_data        = '0;

    tempo_beat_clock #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (BEAT_NUM_W)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .operation       (operation),
        .rate_hz         (rate_hz),
        .requested_tempo (requested_tempo),
        .empty           (empty),
        .pop             (pop),
        .beat_fired      (beat_fired),
        .beat_number     (beat_number),
        .tempo_now       (tempo_now),
        .pulse_level     (pulse_level),
        .running         (running),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------------------------
    // Predictor state: a private copy of the clock and its registers, advanced once per accepted
    // input word, in the order the words were accepted.
    // ------------------------------------------------------------------------------------------
    cfg_t                  model_cfg;
    bit                    clock_running;
    logic [TEMPO_W-1:0]    tempo_cur;
    logic [TEMPO_W-1:0]    tempo_tgt;
    logic [RATE_W-1:0]     rate_used;
    logic [PERIOD_W-1:0]   beat_len;
    logic [PERIOD_W-1:0]   phase_acc;
    logic [BEAT_NUM_W-1:0] beat_count;
    logic [Q16_W-1:0]      pulse_lvl;

    // Result words still owed by the block, oldest first.
    res_t awaited_words[$];

    int errors        = 0;
    int live_words    = 0;  // all words but frame and buffer words sent while the clock is stopped
    int gap_pct       = 0;  // chance in a hundred that the sender idles before a word
    int stall_pct     = 0;  // chance in a hundred that the receiver holds pop low in a cycle
    int hold_requests = 0;  // bumped by the sender to ask for one long receiver hold-off
    int holds_started = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    task automatic reset_model();
        model_cfg.min_tempo    = MIN_TEMPO_RESET;
        model_cfg.max_tempo    = MAX_TEMPO_RESET;
        model_cfg.glide_factor = GLIDE_FACTOR_RESET;
        model_cfg.fade_factor  = FADE_FACTOR_RESET;
        model_cfg.pulse_floor  = PULSE_FLOOR_RESET;
        clock_running = 1'b0;
        tempo_cur     = TEMPO_RESET;
        tempo_tgt     = TEMPO_RESET;
        rate_used     = '0;
        beat_len      = '0;
        phase_acc     = '0;
        beat_count    = '0;
        pulse_lvl     = '0;
    endtask

    // Advances the predicted clock by one command and returns the result word it must produce.
    task automatic tick_tempo_clock(input op_t op, input logic [RATE_W-1:0] rate,
                                    input logic [TEMPO_W-1:0] req, output res_t word);
        logic [TEMPO_W-1:0] clamped;
        logic [RATE_W-1:0]  rate_gap;
        logic [TEMPO_W-1:0] tempo_gap;
        logic [Q16_W-1:0]   weight;
        logic [Q16_W-1:0]   fade;
        logic [63:0]        blend;
        logic [63:0]        quotient;
        logic [63:0]        faded;
        logic               fired;
        fired = 1'b0;
        case (op)
            OP_FRAME:
                // With no period yet, frames move nothing.
                if (clock_running && beat_len != '0)
                begin
                    phase_acc = phase_acc + PHASE_STEP;
                    if (phase_acc >= beat_len)
                    begin
                        phase_acc  = phase_acc - beat_len;
                        beat_count = beat_count + 1'b1;
                        pulse_lvl  = UNITY;
                        fired      = 1'b1;
                    end
                end
            OP_BUF_BEGIN:
                if (clock_running)
                begin
                    // A new rate must differ by at least 2 Hz, unless none is known yet.
                    if (rate != '0)
                    begin
                        rate_gap = (rate > rate_used) ? rate - rate_used : rate_used - rate;
                        if (rate_used == '0 || rate_gap > 1)
                            rate_used = rate;
                    end
                    tempo_gap = (tempo_cur > tempo_tgt) ? tempo_cur - tempo_tgt
                                                        : tempo_tgt - tempo_cur;
                    if (tempo_gap > GLIDE_DEADBAND)
                    begin
                        weight = (model_cfg.glide_factor > UNITY) ? UNITY : model_cfg.glide_factor;
                        blend  = 64'(tempo_cur) * 64'(UNITY - weight)
                               + 64'(tempo_tgt) * 64'(weight) + 64'(ROUND_HALF);
                        tempo_cur = blend[32:16];
                    end
                    if (tempo_cur == '0)
                        beat_len = PERIOD_MAX;
                    else
                    begin
                        quotient = ((64'(rate_used) * 64'(TEMPO_SCALE)) << FRAC_BITS)
                                 / 64'(tempo_cur);
                        beat_len = (quotient > 64'(PERIOD_MAX)) ? PERIOD_MAX : quotient[PERIOD_W-1:0];
                    end
                end
            OP_BUF_END:
                if (clock_running)
                begin
                    fade      = (model_cfg.fade_factor > UNITY) ? UNITY : model_cfg.fade_factor;
                    faded     = (64'(pulse_lvl) * 64'(fade)) >> 16;
                    pulse_lvl = faded[Q16_W-1:0];
                    if (pulse_lvl < model_cfg.pulse_floor)
                        pulse_lvl = '0;
                end
            OP_SET_TEMPO:
            begin
                // Lower limit first: inverted limits give the minimum below it, else the maximum.
                clamped = (req < model_cfg.min_tempo) ? model_cfg.min_tempo :
                          (req > model_cfg.max_tempo) ? model_cfg.max_tempo : req;
                if (clamped != '0 && clamped != tempo_tgt)
                    tempo_tgt = clamped;
            end
            OP_START:
                if (!clock_running)
                begin
                    clock_running = 1'b1;
                    phase_acc     = '0;
                end
            OP_STOP:
                if (clock_running)
                begin
                    clock_running = 1'b0;
                    pulse_lvl     = '0;
                    phase_acc     = '0;
                end
            OP_PAUSE:
                clock_running = 1'b0;
            OP_RESET:
            begin
                clock_running = 1'b0;
                pulse_lvl     = '0;
                phase_acc     = '0;
            end
            default: ;
        endcase
        word.fired       = fired;
        word.beat_number = beat_count;
        word.tempo       = tempo_cur;
        word.pulse       = pulse_lvl;
        word.running     = clock_running;
    endtask

    // ------------------------------------------------------------------------------------------
    // Directed table. Rows with the typed flag carry a result that follows directly from the
    // reset state; the others are checked against the predictor.
    // ------------------------------------------------------------------------------------------
    typedef struct packed {
        op_t                op;
        logic [RATE_W-1:0]  rate;
        logic [TEMPO_W-1:0] req;
        logic               typed;
        res_t               want;
    } step_row_t;

    localparam int DIRECTED_ROWS = 26;
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Everything that needs a running clock is ignored while stopped.
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b0}},
        '{OP_BUF_BEGIN, 18'd48000,  17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b0}},
        '{OP_BUF_END,   18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b0}},
        // Requests below the minimum and above the maximum are clamped, then back to 120 bpm.
        '{OP_SET_TEMPO, 18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b0}},
        '{OP_SET_TEMPO, 18'd0,      17'd100000, 1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b0}},
        '{OP_SET_TEMPO, 18'd0,      17'd12000,  1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b0}},
        '{OP_START,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        // No rate known yet: the period is zero and a frame moves nothing.
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        '{OP_BUF_BEGIN, 18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        // At 10 Hz and 120 bpm a beat is five frames long.
        '{OP_BUF_BEGIN, 18'd10,     17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b0, 32'd0, 17'd12000, 17'd0, 1'b1}},
        '{OP_FRAME,     18'd0,      17'd0,      1'b1, '{1'b1, 32'd1, 17'd12000, 17'd65536, 1'b1}},
        '{OP_BUF_END,   18'd0,      17'd0,      1'b1, '{1'b0, 32'd1, 17'd12000, 17'd62259, 1'b1}},
        // A rate 1 Hz away is not adopted.
        '{OP_BUF_BEGIN, 18'd11,     17'd0,      1'b1, '{1'b0, 32'd1, 17'd12000, 17'd62259, 1'b1}},
        '{OP_SET_TEMPO, 18'd0,      17'd30000,  1'b1, '{1'b0, 32'd1, 17'd12000, 17'd62259, 1'b1}},
        // Full-scale rate with a glide toward 300 bpm.
        '{OP_BUF_BEGIN, 18'h3FFFF,  17'h1FFFF,  1'b0, '0},
        '{OP_FRAME,     18'h3FFFF,  17'h1FFFF,  1'b0, '0},
        '{OP_BUF_END,   18'd0,      17'd0,      1'b0, '0},
        '{OP_PAUSE,     18'd0,      17'd0,      1'b0, '0},
        '{OP_FRAME,     18'd0,      17'd0,      1'b0, '0},
        '{OP_START,     18'd0,      17'd0,      1'b0, '0},
        '{OP_STOP,      18'd0,      17'd0,      1'b0, '0},
        '{OP_RESET,     18'd0,      17'd0,      1'b0, '0}
    };

    // ------------------------------------------------------------------------------------------
    // Sender side. Every task here starts and ends just after a rising edge. Push is left high
    // after an accepted word, so back-to-back words never lower and raise it in one step.
    // ------------------------------------------------------------------------------------------
    task automatic offer_word(input op_t op, input logic [RATE_W-1:0] rate,
                              input logic [TEMPO_W-1:0] req, input bit has_want, input res_t want);
        int   gap;
        res_t predicted;
        if ($urandom_range(99) < gap_pct)
        begin
            // Mostly short gaps, now and then a longer one that can outlast a whole buffer begin.
            gap = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(4, 1);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push            <= 1'b1;
        operation       <= op;
        rate_hz         <= rate;
        requested_tempo <= req;
        do @(posedge clk); while (full);
        if (clock_running || !(op inside {OP_FRAME, OP_BUF_BEGIN, OP_BUF_END}))
            live_words++;
        tick_tempo_clock(op, rate, req, predicted);
        awaited_words.insert(awaited_words.size(), has_want ? want : predicted);
    endtask

    // Stops sending and waits until every owed word has come and the back end has gone quiet.
    task automatic drain_block();
        push <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [Q16_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_MIN_TEMPO:    model_cfg.min_tempo    = value;
            CFG_MAX_TEMPO:    model_cfg.max_tempo    = value;
            CFG_GLIDE_FACTOR: model_cfg.glide_factor = value;
            CFG_FADE_FACTOR:  model_cfg.fade_factor  = value;
            CFG_PULSE_FLOOR:  model_cfg.pulse_floor  = value;
            default: ;  // unused indexes must leave every register alone
        endcase
    endtask

    task automatic apply_settings(input cfg_t setting, input bit with_spares);
        int spare;
        write_register(CFG_MIN_TEMPO, setting.min_tempo);
        write_register(CFG_MAX_TEMPO, setting.max_tempo);
        write_register(CFG_GLIDE_FACTOR, setting.glide_factor);
        write_register(CFG_FADE_FACTOR, setting.fade_factor);
        write_register(CFG_PULSE_FLOOR, setting.pulse_floor);
        if (with_spares)
            for (spare = int'(CFG_PULSE_FLOOR) + 1; spare <= int'(CFG_TOP_INDEX); spare++)
                write_register(CFG_IDX_W'(spare), Q16_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Sample rates: mostly low, so that beats come every few buffers; some close to the rate in
    // use to probe the hysteresis, some zero, some anywhere in the field.
    function automatic logic [RATE_W-1:0] pick_rate();
        int roll;
        int near_rate;
        roll = $urandom_range(99);
        if (roll < 8)
            return '0;
        if (roll < 22)
        begin
            near_rate = int'(rate_used) + int'($urandom_range(4)) - 2;
            return (near_rate <= 0) ? RATE_W'(1) : RATE_W'(near_rate);
        end
        if (roll < 32)
            return RATE_W'($urandom);
        return RATE_W'($urandom_range(120, 1));
    endfunction

    // Tempo requests: zero, repeats of the target, values around both limits, and the whole field.
    function automatic logic [TEMPO_W-1:0] pick_tempo();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return TEMPO_W'($urandom);
        if (roll < 25)
            return tempo_tgt;
        if (roll < 35)
            return model_cfg.min_tempo - 1'b1 + TEMPO_W'($urandom_range(2));
        if (roll < 45)
            return model_cfg.max_tempo - 1'b1 + TEMPO_W'($urandom_range(2));
        return TEMPO_W'($urandom_range(100000));
    endfunction

    // One audio buffer as a host would deliver it: begin, a run of frames, end. The unused fields
    // carry noise.
    task automatic play_buffer();
        int frames;
        frames = $urandom_range(12, 1);
        offer_word(OP_BUF_BEGIN, pick_rate(), TEMPO_W'($urandom), 1'b0, '0);
        repeat (frames)
            offer_word(OP_FRAME, RATE_W'($urandom), TEMPO_W'($urandom), 1'b0, '0);
        offer_word(OP_BUF_END, RATE_W'($urandom), TEMPO_W'($urandom), 1'b0, '0);
    endtask

    // Random traffic until the given number of live words has gone in. Most of it is well-formed
    // buffers on a running clock; the rest is tempo changes, transport commands and noise.
    task automatic run_segment(input int goal);
        int roll;
        int goal_mark;
        goal_mark = live_words + goal;
        while (live_words < goal_mark)
        begin
            if (!clock_running && $urandom_range(9) < 8)
                offer_word(OP_START, RATE_W'($urandom), TEMPO_W'($urandom), 1'b0, '0);
            roll = $urandom_range(99);
            if (roll < 70)
                play_buffer();
            else if (roll < 80)
                offer_word(OP_SET_TEMPO, RATE_W'($urandom), pick_tempo(), 1'b0, '0);
            else if (roll < 88)
                offer_word(op_t'($urandom_range(7, 4)), RATE_W'($urandom), TEMPO_W'($urandom),
                           1'b0, '0);
            else
                offer_word(op_t'($urandom_range(7)), RATE_W'($urandom), TEMPO_W'($urandom),
                           1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        int row;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset settings, with no idling on either side.
        for (row = 0; row < DIRECTED_ROWS; row++)
            offer_word(DIRECTED[row].op, DIRECTED[row].rate, DIRECTED[row].req,
                       DIRECTED[row].typed, DIRECTED[row].want);
        drain_block();

        // Wide-open limits and unity factors: the tempo jumps straight to its target and the
        // pulse never fades. Neither side idles.
        apply_settings('{17'd0, 17'd100000, 17'd65536, 17'd65536, 17'd0}, 1'b0);
        run_segment(SEGMENT_WORDS);
        drain_block();

        // Inverted limits, zero glide and fade, full-scale floor, plus writes to the unused
        // indexes. The sender idles most of the time.
        gap_pct = 78;
        apply_settings('{17'd100000, 17'd0, 17'd0, 17'd0, 17'd65536}, 1'b1);
        run_segment(SEGMENT_WORDS);
        drain_block();

        // Reset values, with the receiver stalling most of the time. Then one long hold-off
        // while the sender keeps pushing without a break, so that both queues fill up.
        gap_pct   = 0;
        stall_pct = 78;
        apply_settings('{MIN_TEMPO_RESET, MAX_TEMPO_RESET, GLIDE_FACTOR_RESET,
                         FADE_FACTOR_RESET, PULSE_FLOOR_RESET}, 1'b0);
        run_segment(SEGMENT_WORDS);
        stall_pct = 0;
        hold_requests++;
        run_segment(60);
        drain_block();

        // Random but sane settings, both sides idling now and then.
        gap_pct   = 16;
        stall_pct = 16;
        apply_settings('{TEMPO_W'($urandom_range(5000)), TEMPO_W'($urandom_range(100000, 20000)),
                         Q16_W'($urandom_range(65536)), Q16_W'($urandom_range(65536, 30000)),
                         Q16_W'($urandom_range(3000))}, 1'b0);
        run_segment(SEGMENT_WORDS);
        drain_block();

        // Factors above unity must saturate; a high floor kills the pulse quickly. No idling,
        // except one pause in the middle until every owed word has come back.
        gap_pct   = 0;
        stall_pct = 0;
        apply_settings('{17'd1000, 17'd50000, 17'h1FFFF, 17'h1FFFF, 17'd30000}, 1'b0);
        run_segment(SEGMENT_WORDS / 2);
        drain_block();
        run_segment(SEGMENT_WORDS / 2);
        drain_block();

        // Limits anywhere in range, possibly inverted; the sender idles again.
        gap_pct = 78;
        apply_settings('{TEMPO_W'($urandom_range(100000)), TEMPO_W'($urandom_range(100000)),
                         Q16_W'($urandom_range(65536)), Q16_W'($urandom_range(65536)),
                         Q16_W'($urandom_range(65536))}, 1'b0);
        run_segment(SEGMENT_WORDS);

        gap_pct   = 0;
        stall_pct = 0;
        drain_block();
        if (errors == 0)
            $display("tb_tempo_beat_clock: PASS");
        else
            $display("tb_tempo_beat_clock: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------------------------
    // Receiver side. A word is taken at an edge where pop was high and empty low, and the ports
    // are sampled at that same edge, before the block moves on.
    // ------------------------------------------------------------------------------------------
    task automatic report_field(input string field, input logic [BEAT_NUM_W-1:0] want,
                                input logic [BEAT_NUM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endtask

    task automatic check_word();
        res_t want_word;
        if (awaited_words.size() == 0)
        begin
            $display("%0t: result word with nothing expected (beat_number %0d)", $time, beat_number);
            errors++;
        end
        else
        begin
            want_word = awaited_words.pop_front();
            report_field("beat_fired", want_word.fired, beat_fired);
            report_field("beat_number", want_word.beat_number, beat_number);
            report_field("tempo_now", want_word.tempo, tempo_now);
            report_field("pulse_level", want_word.pulse, pulse_level);
            report_field("running", want_word.running, running);
        end
    endtask

    always @(posedge clk)
    begin : result_taker
        if (rst_n && pop && !empty)
            check_word();
        // A requested hold-off keeps pop low for a fixed stretch, counted here.
        if (hold_left > 0)
            hold_left--;
        else if (holds_started != hold_requests)
        begin
            holds_started++;
            hold_left = HOLD_CYCLES;
        end
        pop <= rst_n && hold_left == 0 && ($urandom_range(99) >= stall_pct);
    end

    // Ends the run if no word moves on any channel for too long.
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles, %0d results still owed",
                     $time, quiet_cycles, awaited_words.size());
            $display("tb_tempo_beat_clock: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
